[rtl/bqeq_pkg.sv]
// Shared types and constants for the biquad peaking EQ cascade.
// No dependencies; imported by bqeq_mac, the top level and the bench.
package bqeq_pkg;

  localparam int CHANNELS    = 8;
  localparam int BANDS       = 5;
  localparam int SAMPLE_BITS = 24;

  localparam int CH_W       = 3;
  localparam int COEF_BITS  = 16;
  localparam int COEF_FRAC  = 13;
  localparam int HIST_DEPTH = CHANNELS * BANDS;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;

  // product of a sample and a coefficient; five of them summed need 3 more bits
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;

  // configuration port
  localparam int NUM_REGS = 7;
  localparam int REG_W    = 64;
  localparam int PADDR_W  = $clog2(NUM_REGS * 8);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    coef_t a2;
    coef_t b2;
    coef_t b1;
    coef_t b0;
  } coef_set_t;

  // one history word per channel and band
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic sub;
  } mac_ctrl_t;

endpackage

[rtl/bqeq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bqeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/bqeq_mac.sv]
// Shared multiply-accumulate unit: registered product, then add or subtract.
// Depends on bqeq_pkg.
module bqeq_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqeq_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] a_i,
  input  logic signed [bqeq_pkg::COEF_BITS-1:0]   b_i,
  output logic signed [bqeq_pkg::ACC_W-1:0]       acc_o
);
  import bqeq_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     add_q, sub_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
      sub_q <= 1'b0;
      acc_q <= '0;
    end else begin
      add_q <= ctrl_i.mul_en;
      sub_q <= ctrl_i.sub;
      priority if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (add_q) begin
        acc_q <= sub_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/biquad_peaking_eq_cascade.sv]
// Top level of the biquad peaking EQ cascade: config registers, sequencer,
// history RAM and the shared MAC. Depends on bqeq_pkg, bqeq_ram, bqeq_mac.
//
//   channel   valid        stall         payload
//   -------   ----------   -----------   ------------------------------------
//   input     in_valid_i   in_stall_o    sample_in_i, channel_i, segment_start_i
//   output    out_valid_o  out_stall_i   sample_out_o, channel_out_o
//   config    APB psel/penable/pwrite    paddr (8 bytes per register), pwdata
//
// Each active band reads its history, then runs five products through the
// shared multiplier, drains the accumulator, and rounds and writes back;
// a bypassed band is skipped and a disabled block passes the sample through.
// Reset clears config to its defaults and the per-entry history valid bits, so
// history reads as zero at once; a segment start clears that channel's bits.
// in_stall_o is high from acceptance until the result is loaded into the
// output register; a stalled output holds the next result in the sequencer.
module biquad_peaking_eq_cascade (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [bqeq_pkg::PADDR_W-1:0]            paddr,
  input  logic [bqeq_pkg::REG_W-1:0]              pwdata,
  output logic [bqeq_pkg::REG_W-1:0]              prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [bqeq_pkg::CH_W-1:0]               channel_i,
  input  logic                                    segment_start_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [bqeq_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [bqeq_pkg::CH_W-1:0]               channel_out_o
);
  import bqeq_pkg::*;

  // register indexes
  localparam int IDX_W      = PADDR_W - 3;
  localparam int REG_ENABLE = 0;
  localparam int REG_MASK   = 1;
  localparam int REG_COEF0  = 2;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BAND = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // MAC steps within one band
  localparam logic [2:0] STEP_X0 = 3'd0;
  localparam logic [2:0] STEP_X1 = 3'd1;
  localparam logic [2:0] STEP_X2 = 3'd2;
  localparam logic [2:0] STEP_Y1 = 3'd3;
  localparam logic [2:0] STEP_Y2 = 3'd4;

  localparam int SH_W = ACC_W - COEF_FRAC;

  // ---------------- configuration ----------------
  logic             enable_q;
  logic [BANDS-1:0] mask_q;
  coef_set_t        coef_q [BANDS];
  logic             wr_en;
  logic [IDX_W-1:0] widx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign widx   = paddr[PADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      mask_q   <= '0;
      for (int b = 0; b < BANDS; b++) begin
        coef_q[b] <= '0;
      end
    end else if (wr_en) begin
      if (widx == IDX_W'(REG_ENABLE)) begin
        enable_q <= pwdata[0];
      end
      if (widx == IDX_W'(REG_MASK)) begin
        mask_q <= pwdata[BANDS-1:0];
      end
      for (int b = 0; b < BANDS; b++) begin
        if (widx == IDX_W'(REG_COEF0 + b)) begin
          coef_q[b] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (widx == IDX_W'(REG_ENABLE)) begin
      prdata = REG_W'(enable_q);
    end
    if (widx == IDX_W'(REG_MASK)) begin
      prdata = REG_W'(mask_q);
    end
    for (int b = 0; b < BANDS; b++) begin
      if (widx == IDX_W'(REG_COEF0 + b)) begin
        prdata = coef_q[b];
      end
    end
  end

  // ---------------- datapath state ----------------
  logic [2:0]            state_q, state_d;
  logic [BAND_W-1:0]     band_q, band_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [2:0]            step_q, step_d;
  sample_t               x_q, x_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic                  rd_vld_q;
  logic [HIST_DEPTH-1:0] hist_vld_q, hist_vld_d;
  logic                  out_vld_q;
  sample_t               sample_out_q;
  logic [CH_W-1:0]       ch_out_q;

  logic                  ram_re, ram_we, out_load, advance, ch_ok;
  logic [ADDR_W-1:0]     base_addr;
  mac_ctrl_t             mac_ctrl;
  sample_t               mac_a;
  coef_t                 mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rsum;
  logic [SH_W-1:0]       shifted;
  logic [SH_W-SAMPLE_BITS:0] upper;
  sample_t               y_sat;
  hist_t                 rd_raw, hist_rd, hist_wr;
  coef_set_t             coef_cur;

  assign ch_ok     = int'(channel_i) < CHANNELS;
  assign base_addr = ADDR_W'(int'(channel_i) * BANDS);
  assign coef_cur  = coef_q[band_q];
  // an entry never written since reset or segment start reads as zero
  assign hist_rd   = rd_vld_q ? rd_raw : '0;

  // round half up, then saturate
  assign rsum    = acc + ACC_W'(1 << (COEF_FRAC - 1));
  assign shifted = rsum[ACC_W-1:COEF_FRAC];
  assign upper   = shifted[SH_W-1:SAMPLE_BITS-1];
  always_comb begin
    if ((&upper) || !(|upper)) begin
      y_sat = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SH_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign hist_wr.x1 = x_q;
  assign hist_wr.x2 = hist_rd.x1;
  assign hist_wr.y1 = y_sat;
  assign hist_wr.y2 = hist_rd.y1;

  // operand select: b0*x, b1*x1, b2*x2, then subtract b1*y1 and a2*y2
  always_comb begin
    unique case (step_q)
      STEP_X0: begin mac_a = x_q;        mac_b = coef_cur.b0; end
      STEP_X1: begin mac_a = hist_rd.x1; mac_b = coef_cur.b1; end
      STEP_X2: begin mac_a = hist_rd.x2; mac_b = coef_cur.b2; end
      STEP_Y1: begin mac_a = hist_rd.y1; mac_b = coef_cur.b1; end
      STEP_Y2: begin mac_a = hist_rd.y2; mac_b = coef_cur.a2; end
      default: begin mac_a = '0;         mac_b = '0;          end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    band_d     = band_q;
    addr_d     = addr_q;
    step_d     = step_q;
    x_d        = x_q;
    ch_d       = ch_q;
    hist_vld_d = hist_vld_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    mac_ctrl   = '0;
    out_load   = 1'b0;
    advance    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d    = sample_in_i;
          ch_d   = channel_i;
          band_d = '0;
          addr_d = base_addr;
          if (segment_start_i && ch_ok) begin
            for (int c = 0; c < CHANNELS; c++) begin
              for (int b = 0; b < BANDS; b++) begin
                if (int'(channel_i) == c) begin
                  hist_vld_d[c*BANDS+b] = 1'b0;
                end
              end
            end
          end
          state_d = (enable_q && ch_ok) ? S_BAND : S_DONE;
        end
      end
      S_BAND: begin
        if (mask_q[band_q]) begin
          ram_re       = 1'b1;
          mac_ctrl.clr = 1'b1;
          step_d       = STEP_X0;
          state_d      = S_MAC;
        end else begin
          advance = 1'b1;
        end
      end
      S_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sub    = (step_q == STEP_Y1) || (step_q == STEP_Y2);
        if (step_q == STEP_Y2) begin
          state_d = S_ACC;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_ACC: begin
        state_d = S_WB;
      end
      S_WB: begin
        ram_we             = 1'b1;
        hist_vld_d[addr_q] = 1'b1;
        x_d                = y_sat;
        state_d            = S_BAND;
        advance            = 1'b1;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (advance) begin
      if (band_q == BAND_W'(BANDS - 1)) begin
        state_d = S_DONE;
      end else begin
        band_d = band_q + BAND_W'(1);
        addr_d = addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      band_q     <= '0;
      addr_q     <= '0;
      step_q     <= STEP_X0;
      rd_vld_q   <= 1'b0;
      hist_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      band_q     <= band_d;
      addr_q     <= addr_d;
      step_q     <= step_d;
      hist_vld_q <= hist_vld_d;
      if (ram_re) begin
        rd_vld_q <= hist_vld_q[addr_q];
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    ch_q <= ch_d;
    if (out_load) begin
      sample_out_q <= x_q;
      ch_out_q     <= ch_q;
    end
  end

  // ---------------- units ----------------
  bqeq_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (hist_wr),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (rd_raw)
  );

  bqeq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_vld_q;
  assign sample_out_o  = sample_out_q;
  assign channel_out_o = ch_out_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for biquad_peaking_eq_cascade: an internal filter
// predictor, random handshake gaps and APB register setup. Depends on bqeq_pkg.
module testbench;
  import bqeq_pkg::*;

  // Register map: one 64-bit register every 8 bytes. Index 7 is not mapped
  // and a write there must leave the block untouched.
  typedef enum int {
    REG_EFFECT_ENABLE = 0,
    REG_BAND_MASK     = 1,
    REG_BAND0_COEF    = 2,
    REG_BAND1_COEF    = 3,
    REG_BAND2_COEF    = 4,
    REG_BAND3_COEF    = 5,
    REG_BAND4_COEF    = 6,
    REG_UNMAPPED      = 7
  } reg_index_e;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t   COEF_ONE   = 16'sd8192;  // 1.0 in Q2.13
  localparam coef_t   COEF_MAX   = 16'sh7fff;
  localparam coef_t   COEF_MIN   = 16'sh8000;
  localparam int      DRAIN_CYCLES = 60;       // a bit over the worst-case transaction

  typedef struct {
    sample_t          sample;
    logic [CH_W-1:0]  ch;
  } eq_result_t;

  // DUT ports; every input has a known value from time zero
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   psel            = 1'b0;
  logic                   penable         = 1'b0;
  logic                   pwrite          = 1'b0;
  logic [PADDR_W-1:0]     paddr           = '0;
  logic [REG_W-1:0]       pwdata          = '0;
  logic [REG_W-1:0]       prdata;
  logic                   pready;
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  sample_t                sample_in_i     = '0;
  logic [CH_W-1:0]        channel_i       = '0;
  logic                   segment_start_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  sample_t                sample_out_o;
  logic [CH_W-1:0]        channel_out_o;

  // Predictor state: register mirror plus per channel/band filter history
  logic                   eq_enable;
  logic [BANDS-1:0]       eq_band_mask;
  coef_set_t              eq_coefs [BANDS];
  hist_t                  eq_hist [HIST_DEPTH];

  eq_result_t             expected_results [$];
  int                     mismatch_count = 0;
  int                     out_stall_left = 0;
  logic                   calm = 1'b0;   // stretches with no gaps at all

  always #1 clk_i = ~clk_i;

  biquad_peaking_eq_cascade i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .channel_i       (channel_i),
    .segment_start_i (segment_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .channel_out_o   (channel_out_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_eq_state();
    eq_enable    = 1'b1;
    eq_band_mask = '0;
    for (int b = 0; b < BANDS; b++) eq_coefs[b] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) eq_hist[i] = '0;
  endfunction

  function automatic void apply_register_write(reg_index_e idx, logic [REG_W-1:0] value);
    case (idx)
      REG_EFFECT_ENABLE: eq_enable    = value[0];
      REG_BAND_MASK:     eq_band_mask = value[BANDS-1:0];
      REG_BAND0_COEF, REG_BAND1_COEF, REG_BAND2_COEF, REG_BAND3_COEF, REG_BAND4_COEF: begin
        if (int'(idx) - int'(REG_BAND0_COEF) < BANDS)
          eq_coefs[int'(idx) - int'(REG_BAND0_COEF)] = value;
      end
      default: ;  // unmapped: dropped
    endcase
  endfunction

  // Appends one prediction at the tail of the scoreboard queue.
  function automatic void queue_prediction(eq_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Runs one sample through the active bands, updating that channel's history.
  // Each band: y = b0*x + b1*x1 + b2*x2 - b1*y1 - a2*y2, round half up,
  // saturate to the sample width; the result feeds the next band.
  function automatic eq_result_t equalize_sample(sample_t x_in, logic [CH_W-1:0] ch,
                                                 logic seg);
    eq_result_t r;
    longint     x;
    longint     acc;
    longint     y;
    int         idx;
    coef_set_t  c;
    hist_t      h;
    x = longint'(x_in);
    if (int'(ch) < CHANNELS) begin
      if (seg)
        for (int b = 0; b < BANDS; b++) eq_hist[int'(ch) * BANDS + b] = '0;
      if (eq_enable) begin
        for (int b = 0; b < BANDS; b++) begin
          if (eq_band_mask[b]) begin
            idx = int'(ch) * BANDS + b;
            c   = eq_coefs[b];
            h   = eq_hist[idx];
            acc = longint'(c.b0) * x
                + longint'(c.b1) * longint'(h.x1)
                + longint'(c.b2) * longint'(h.x2)
                - longint'(c.b1) * longint'(h.y1)
                - longint'(c.a2) * longint'(h.y2);
            y = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;  // floor shift
            if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
            if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
            h.x2 = h.x1;
            h.x1 = sample_t'(x);
            h.y2 = h.y1;
            h.y1 = sample_t'(y);
            eq_hist[idx] = h;
            x = y;
          end
        end
      end
    end
    r.sample = sample_t'(x);
    r.ch     = ch;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
    if (r < 30) return sample_t'(int'($urandom_range(0, 4000)) - 2000);
    return sample_t'($urandom);
  endfunction

  // Roughly what a peaking section looks like: gain near one, poles inside.
  function automatic coef_set_t stable_coefs();
    coef_set_t c;
    int        lim;
    c.a2 = coef_t'(int'($urandom_range(0, 9000)) - 3000);
    lim  = 8192 + int'(c.a2) - 600;
    c.b1 = coef_t'(int'($urandom_range(0, 2 * lim)) - lim);
    c.b0 = coef_t'(int'($urandom_range(6000, 11000)));
    c.b2 = coef_t'(int'($urandom_range(0, 12000)) - 6000);
    return c;
  endfunction

  // Output side back-pressure, changed on the falling edge only.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm = ~calm;
    if (out_stall_left == 0) out_stall_left = pick_gap();
    if (out_stall_left > 0) begin
      out_stall_i    = 1'b1;
      out_stall_left = out_stall_left - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Transaction drivers (all start and end at a falling edge)
  // ---------------------------------------------------------------------------

  // Offers one sample; valid stays high afterwards so back-to-back
  // transactions need no second assignment in the same step.
  task automatic send_sample(sample_t s, logic [CH_W-1:0] ch, logic seg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    sample_in_i     = s;
    channel_i       = ch;
    segment_start_i = seg;
    do @(posedge clk_i); while (in_stall_o);
    queue_prediction(equalize_sample(s, ch, seg));
    @(negedge clk_i);
  endtask

  // Register writes only while idle: input parked and every result drained.
  task automatic write_reg(reg_index_e idx, logic [REG_W-1:0] value);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(int'(idx) * 8);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    apply_register_write(idx, value);
  endtask

  task automatic write_band(int b, coef_set_t c);
    write_reg(reg_index_e'(int'(REG_BAND0_COEF) + b), c);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compares each accepted output with the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic count_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : check_output
    eq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        count_failure($sformatf("unexpected result: sample_out %0d channel_out %0d",
                                sample_out_o, channel_out_o));
      end else begin
        want = expected_results.pop_front();
        if (sample_out_o !== want.sample)
          count_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                  want.sample, sample_out_o));
        if (channel_out_o !== want.ch)
          count_failure($sformatf("channel_out mismatch: expected %0d, got %0d",
                                  want.ch, channel_out_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the block is enabled with every band masked: pure bypass.
  task automatic test_reset_bypass();
    send_sample(SAMPLE_MAX, 3'd0, 1'b0);
    send_sample(SAMPLE_MIN, 3'd7, 1'b1);
    send_sample('0,         3'd3, 1'b0);
    send_sample(sample_t'(-1), 3'd5, 1'b1);
  endtask

  // Disabled block passes samples unchanged; segment start still clears.
  task automatic test_disabled_passthrough();
    write_reg(REG_BAND_MASK, 64'h1f);
    for (int b = 0; b < BANDS; b++) write_band(b, stable_coefs());
    write_reg(REG_EFFECT_ENABLE, 64'h0);
    send_sample(sample_t'(24'h123456), 3'd2, 1'b0);
    send_sample(SAMPLE_MIN,            3'd2, 1'b1);
    send_sample(SAMPLE_MAX,            3'd6, 1'b0);
    send_sample(sample_t'(24'hedcba9), 3'd1, 1'b1);
    write_reg(REG_EFFECT_ENABLE, 64'h1);
  endtask

  // Identity section, then coefficients at both extremes to force clipping,
  // then a recursive section so the history path matters.
  task automatic test_gain_and_saturation();
    write_reg(REG_BAND_MASK, 64'h01);
    write_band(0, '{a2: 16'sd0, b2: 16'sd0, b1: 16'sd0, b0: COEF_ONE});
    send_sample(SAMPLE_MAX, 3'd4, 1'b1);
    send_sample(SAMPLE_MIN, 3'd4, 1'b0);
    write_band(0, '{a2: 16'sd0, b2: 16'sd0, b1: 16'sd0, b0: COEF_MAX});
    send_sample(SAMPLE_MAX, 3'd4, 1'b1);
    send_sample(SAMPLE_MIN, 3'd4, 1'b0);
    write_band(0, '{a2: COEF_MIN, b2: COEF_MIN, b1: COEF_MIN, b0: COEF_MIN});
    send_sample(SAMPLE_MIN, 3'd0, 1'b1);
    send_sample(SAMPLE_MAX, 3'd0, 1'b0);
    write_band(0, '{a2: 16'sd2048, b2: 16'sd1024, b1: -16'sd4096, b0: COEF_ONE});
    send_sample(sample_t'(24'h400000), 3'd1, 1'b1);
    send_sample(sample_t'(-24'sd1000), 3'd1, 1'b0);
  endtask

  // A bypassed band keeps its history and resumes from it once re-enabled.
  task automatic test_bypass_resume();
    write_reg(REG_BAND_MASK, 64'h03);
    write_band(0, '{a2: 16'sd0, b2: 16'sd0, b1: 16'sd0, b0: COEF_ONE});
    write_band(1, '{a2: 16'sd0, b2: 16'sd0, b1: 16'sd4096, b0: COEF_ONE});
    send_sample(sample_t'(24'h100000), 3'd1, 1'b1);
    send_sample(sample_t'(24'h080000), 3'd1, 1'b0);
    write_reg(REG_BAND_MASK, 64'h01);
    send_sample(sample_t'(24'h200000), 3'd1, 1'b0);
    write_reg(REG_BAND_MASK, 64'h03);
    send_sample(sample_t'(24'h010000), 3'd1, 1'b0);
    send_sample(sample_t'(-24'sd5),    3'd1, 1'b0);
  endtask

  // Writes to the unmapped slot must not disturb any register.
  task automatic test_unmapped_register();
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    send_sample(sample_t'(24'h3abcde), 3'd1, 1'b0);
    write_reg(REG_UNMAPPED, '1);
    send_sample(sample_t'(24'hc00001), 3'd5, 1'b0);
  endtask

  // Full reprogramming at the start of a phase; wide random values check
  // that only the defined bits take effect.
  task automatic configure_phase(int phase);
    logic [REG_W-1:0] w;
    coef_set_t        c;
    w    = {$urandom, $urandom};
    w[0] = (phase != 4);
    write_reg(REG_EFFECT_ENABLE, w);
    w = {$urandom, $urandom};
    case (phase)
      0, 2, 3: w[BANDS-1:0] = '1;
      1:       w[BANDS-1:0] = '0;
      default: ;
    endcase
    write_reg(REG_BAND_MASK, w);
    for (int b = 0; b < BANDS; b++) begin
      case (phase)
        2:       c = '{a2: COEF_MAX, b2: COEF_MAX, b1: COEF_MAX, b0: COEF_MAX};
        3:       c = '{a2: COEF_MIN, b2: COEF_MIN, b1: COEF_MIN, b0: COEF_MIN};
        4:       c = {$urandom, $urandom};
        default: c = ($urandom_range(0, 3) == 0) ? coef_set_t'({$urandom, $urandom})
                                                 : stable_coefs();
      endcase
      write_band(b, c);
    end
  endtask

  // Runs of samples on one channel, as a stream would arrive, with segment
  // starts mostly at the head of a run and occasionally mid-run.
  task automatic test_random_traffic();
    int   ch;
    int   run_left;
    logic seg;
    for (int phase = 0; phase < 9; phase++) begin
      configure_phase(phase);
      run_left = 0;
      ch       = 0;
      for (int n = 0; n < 50; n++) begin
        seg = 1'b0;
        if (run_left == 0) begin
          ch       = $urandom_range(0, CHANNELS - 1);
          run_left = $urandom_range(1, 12);
          seg      = ($urandom_range(0, 3) == 0);
        end else if ($urandom_range(0, 40) == 0) begin
          seg = 1'b1;
        end
        run_left--;
        send_sample(random_sample(), CH_W'(ch), seg);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_eq_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_bypass();
    test_disabled_passthrough();
    test_gain_and_saturation();
    test_bypass_resume();
    test_unmapped_register();
    test_random_traffic();

    // drain, then give any stray result time to show up
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule

[biquad_peaking_eq_cascade.f]
rtl/bqeq_pkg.sv
rtl/bqeq_ram.sv
rtl/bqeq_mac.sv
rtl/biquad_peaking_eq_cascade.sv
bench/testbench.sv
